// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, codes and constants shared by the round-robin thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int MAX_THREADS_DEF = 128;

  // Event codes.
  localparam logic [2:0] FN_SPAWN  = 3'd0;
  localparam logic [2:0] FN_TERM   = 3'd1;
  localparam logic [2:0] FN_BLOCK  = 3'd2;
  localparam logic [2:0] FN_RESUME = 3'd3;
  localparam logic [2:0] FN_SLEEP  = 3'd4;
  localparam logic [2:0] FN_TICK   = 3'd5;
  localparam logic [2:0] FN_QUERY  = 3'd6;

  // Result status codes.
  localparam logic [2:0] RS_OK     = 3'd0;
  localparam logic [2:0] RS_BAD_ID = 3'd1;
  localparam logic [2:0] RS_MAIN   = 3'd2;
  localparam logic [2:0] RS_FULL   = 3'd3;
  localparam logic [2:0] RS_ZERO   = 3'd4;
  localparam logic [2:0] RS_END    = 3'd5;

  typedef enum logic [1:0] {
    TS_FREE, TS_READY, TS_RUNNING, TS_BLOCKED
  } tstat_t;

  typedef struct packed {
    tstat_t      st;
    logic        asleep;
    logic [15:0] sleep_left;
    logic [31:0] quanta;
  } tt_entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  thread_id;
    logic [15:0] sleep_quanta;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [6:0]  running_id;
    logic [31:0] total_quanta;
    logic        switched;
  } out_item_t;

  typedef enum logic [4:0] {
    CS_RST_CLR, CS_IDLE, CS_FETCH, CS_DECIDE, CS_TRM_CLR, CS_SPN_RD, CS_SPN_CHK,
    CS_RM_RD, CS_RM_WR, CS_AGE_RD, CS_AGE_WR, CS_REQ_RD, CS_REQ_WR, CS_DSP,
    CS_DSP_Q, CS_DSP_WR, CS_SLP_RD, CS_SLP_WR, CS_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_RD_TGT, OP_RD_IDX, OP_RD_CUR, OP_SET_ST,
    OP_FREE, OP_WR_TGT, OP_QUERY, OP_SPAWN, OP_IDX_INC, OP_RM_RD, OP_RM_STEP,
    OP_RM_END, OP_AGE, OP_REQ, OP_DSP_RD, OP_POP, OP_DSP_WR, OP_SLP_WR, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       idx_clr;
    logic [2:0] code;
    tstat_t     tstat;
    logic       push;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       tgt_valid;
    tstat_t     tgt_st;
    logic       tgt_main;
    logic       tgt_cur;
    logic       live_full;
    logic       n_zero;
    logic       cur_main;
    logic       idx_last;
    logic       rm_end;
    logic       q_empty;
    logic       rd_free;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rrts_datapath.sv -----
// ----------------------------------------------------------------------------
// rrts_datapath
// Thread table, ready FIFO, scheduler registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_datapath #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  rrts_pkg::dp_cmd_t   cmd,
  output rrts_pkg::dp_sts_t   sts,
  input  rrts_pkg::in_item_t  req,
  input  wire                 rsp_stall,
  output logic                rsp_valid,
  output rrts_pkg::out_item_t rsp
);

  localparam int ID_W  = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(MAX_THREADS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_THREADS - 1);

  rrts_pkg::tt_entry_t tt_mem [MAX_THREADS];
  logic [ID_W-1:0]     q_mem  [MAX_THREADS];

  rrts_pkg::tt_entry_t tt_rd;
  logic [ID_W-1:0]     q_rd;

  logic [2:0]       req_func;
  logic [6:0]       req_tid;
  logic [15:0]      req_n;
  logic [ID_W-1:0]  head;
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  current;
  logic [31:0]      total;
  logic [CNT_W-1:0] live;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] kept;
  logic [ID_W-1:0]  pop_id;
  logic [2:0]       res_status;
  logic [31:0]      res_value;
  logic             res_sw;

  logic                tt_re, tt_we, q_re, q_we, push_en, push_ok, in_range;
  logic [ID_W-1:0]     tt_raddr, tt_waddr, q_raddr, q_waddr, q_wdata, push_id;
  logic [ID_W-1:0]     t_addr, idx_a;
  rrts_pkg::tt_entry_t tt_wdata, age_e, main_e;

  function automatic logic [ID_W-1:0] wrap_add(input logic [ID_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(MAX_THREADS)) s = s - (CNT_W+1)'(MAX_THREADS);
    return ID_W'(s);
  endfunction

  assign t_addr   = ID_W'(req_tid);
  assign idx_a    = ID_W'(idx);
  assign in_range = {25'd0, req_tid} < 32'(MAX_THREADS);
  assign push_ok  = push_en && (count < N_CNT);

  always_comb begin
    main_e            = '0;
    main_e.st         = rrts_pkg::TS_RUNNING;
    main_e.quanta     = 32'd1;
  end

  // One aging step: a sleeper counts down and wakes when it reaches zero.
  always_comb begin
    age_e = tt_rd;
    if (tt_rd.asleep) begin
      if (tt_rd.sleep_left != 16'd0) age_e.sleep_left = tt_rd.sleep_left - 16'd1;
      if (age_e.sleep_left == 16'd0) age_e.asleep = 1'b0;
    end
  end

  always_comb begin
    tt_re    = 1'b0;
    tt_raddr = '0;
    tt_we    = 1'b0;
    tt_waddr = '0;
    tt_wdata = tt_rd;
    q_re     = 1'b0;
    q_raddr  = '0;
    q_we     = 1'b0;
    q_waddr  = '0;
    q_wdata  = q_rd;
    push_en  = 1'b0;
    push_id  = '0;
    case (cmd.op)
      rrts_pkg::OP_RD_TGT: begin
        tt_re    = 1'b1;
        tt_raddr = in_range ? t_addr : '0;
      end
      rrts_pkg::OP_RD_IDX: begin
        tt_re    = 1'b1;
        tt_raddr = idx_a;
      end
      rrts_pkg::OP_RD_CUR: begin
        tt_re    = 1'b1;
        tt_raddr = current;
      end
      rrts_pkg::OP_POP: begin
        tt_re    = 1'b1;
        tt_raddr = q_rd;
      end
      rrts_pkg::OP_CLR: begin
        tt_we    = 1'b1;
        tt_waddr = idx_a;
        tt_wdata = (idx == '0) ? main_e : '0;
      end
      rrts_pkg::OP_FREE: begin
        tt_we    = 1'b1;
        tt_waddr = t_addr;
        tt_wdata = '0;
      end
      rrts_pkg::OP_WR_TGT: begin
        tt_we       = 1'b1;
        tt_waddr    = t_addr;
        tt_wdata.st = cmd.tstat;
        push_en     = cmd.push && !tt_rd.asleep;
        push_id     = t_addr;
      end
      rrts_pkg::OP_SPAWN: begin
        tt_we       = 1'b1;
        tt_waddr    = idx_a;
        tt_wdata    = '0;
        tt_wdata.st = rrts_pkg::TS_READY;
        push_en     = 1'b1;
        push_id     = idx_a;
      end
      rrts_pkg::OP_RM_RD: begin
        q_re    = 1'b1;
        q_raddr = wrap_add(head, idx);
      end
      rrts_pkg::OP_RM_STEP: begin
        q_we    = (q_rd != t_addr);
        q_waddr = wrap_add(head, kept);
      end
      rrts_pkg::OP_AGE: begin
        tt_we    = 1'b1;
        tt_waddr = idx_a;
        tt_wdata = age_e;
        push_en  = tt_rd.asleep && !age_e.asleep && (tt_rd.st == rrts_pkg::TS_READY);
        push_id  = idx_a;
      end
      rrts_pkg::OP_REQ: begin
        tt_we       = (tt_rd.st == rrts_pkg::TS_RUNNING);
        tt_waddr    = current;
        tt_wdata.st = rrts_pkg::TS_READY;
        push_en     = (tt_rd.st == rrts_pkg::TS_RUNNING);
        push_id     = current;
      end
      rrts_pkg::OP_DSP_RD: begin
        q_re    = 1'b1;
        q_raddr = head;
      end
      rrts_pkg::OP_DSP_WR: begin
        tt_we           = 1'b1;
        tt_waddr        = pop_id;
        tt_wdata.st     = rrts_pkg::TS_RUNNING;
        tt_wdata.quanta = tt_rd.quanta + 32'd1;
      end
      rrts_pkg::OP_SLP_WR: begin
        tt_we               = 1'b1;
        tt_waddr            = current;
        tt_wdata.st         = rrts_pkg::TS_READY;
        tt_wdata.asleep     = 1'b1;
        tt_wdata.sleep_left = req_n;
      end
      default: ;
    endcase
    if (push_ok) begin
      q_we    = 1'b1;
      q_waddr = wrap_add(head, count);
      q_wdata = push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
    if (tt_re) tt_rd <= tt_mem[tt_raddr];
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      idx       <= '0;
      kept      <= '0;
      head      <= '0;
      count     <= '0;
      current   <= '0;
      total     <= 32'd1;
      live      <= CNT_W'(1);
    end else begin
      case (cmd.op)
        rrts_pkg::OP_LOAD: begin
          req_func   <= req.func;
          req_tid    <= req.thread_id;
          req_n      <= req.sleep_quanta;
          res_status <= rrts_pkg::RS_OK;
          res_value  <= 32'd0;
          res_sw     <= 1'b0;
        end
        rrts_pkg::OP_CLR: begin
          idx     <= idx + CNT_W'(1);
          head    <= '0;
          count   <= '0;
          current <= '0;
          total   <= 32'd1;
          live    <= CNT_W'(1);
        end
        rrts_pkg::OP_SET_ST: res_status <= cmd.code;
        rrts_pkg::OP_FREE: if (live != '0) live <= live - CNT_W'(1);
        rrts_pkg::OP_QUERY: res_value <= tt_rd.quanta;
        rrts_pkg::OP_SPAWN: begin
          live      <= live + CNT_W'(1);
          res_value <= 32'(idx);
        end
        rrts_pkg::OP_IDX_INC, rrts_pkg::OP_AGE: idx <= idx + CNT_W'(1);
        rrts_pkg::OP_RM_STEP: begin
          idx <= idx + CNT_W'(1);
          if (q_rd != t_addr) kept <= kept + CNT_W'(1);
        end
        rrts_pkg::OP_RM_END: count <= kept;
        rrts_pkg::OP_POP: begin
          pop_id <= q_rd;
          head   <= wrap_add(head, CNT_W'(1));
          count  <= count - CNT_W'(1);
        end
        rrts_pkg::OP_DSP_WR: begin
          current <= pop_id;
          total   <= total + 32'd1;
          res_sw  <= 1'b1;
        end
        default: ;
      endcase
      if (push_ok) count <= count + CNT_W'(1);
      if (cmd.idx_clr) begin
        idx  <= '0;
        kept <= '0;
      end
      if (cmd.op == rrts_pkg::OP_EMIT) begin
        rsp_valid        <= 1'b1;
        rsp.status       <= res_status;
        rsp.value        <= res_value;
        rsp.running_id   <= 7'(current);
        rsp.total_quanta <= total;
        rsp.switched     <= res_sw;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.func      = req_func;
    sts.tgt_valid = in_range && (tt_rd.st != rrts_pkg::TS_FREE);
    sts.tgt_st    = tt_rd.st;
    sts.tgt_main  = (req_tid == 7'd0);
    sts.tgt_cur   = in_range && (t_addr == current);
    sts.live_full = (live >= N_CNT);
    sts.n_zero    = (req_n == 16'd0);
    sts.cur_main  = (current == '0);
    sts.idx_last  = (idx == LAST_IDX);
    sts.rm_end    = (idx == count);
    sts.q_empty   = (count == '0);
    sts.rd_free   = (tt_rd.st == rrts_pkg::TS_FREE);
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire

// ----- rtl/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer of the scheduler: decodes each event and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t cmd
);

  rrts_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rrts_pkg::CS_RST_CLR;
    else     state <= state_next;
  end

  assign req_stall = (state != rrts_pkg::CS_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      rrts_pkg::CS_RST_CLR: if (sts.idx_last) state_next = rrts_pkg::CS_IDLE;
      rrts_pkg::CS_IDLE:    if (req_valid) state_next = rrts_pkg::CS_FETCH;
      rrts_pkg::CS_FETCH:   state_next = rrts_pkg::CS_DECIDE;
      rrts_pkg::CS_DECIDE: begin
        state_next = rrts_pkg::CS_DONE;
        case (sts.func)
          rrts_pkg::FN_SPAWN:
            if (!sts.live_full) state_next = rrts_pkg::CS_SPN_RD;
          rrts_pkg::FN_TERM, rrts_pkg::FN_BLOCK: begin
            if (!sts.tgt_valid) state_next = rrts_pkg::CS_DONE;
            else if (sts.tgt_main)
              state_next = (sts.func == rrts_pkg::FN_TERM) ? rrts_pkg::CS_TRM_CLR
                                                           : rrts_pkg::CS_DONE;
            else if (sts.tgt_st == rrts_pkg::TS_BLOCKED) state_next = rrts_pkg::CS_DONE;
            else if (sts.tgt_cur && sts.tgt_st == rrts_pkg::TS_RUNNING)
              state_next = rrts_pkg::CS_AGE_RD;
            else if (sts.tgt_st == rrts_pkg::TS_READY) state_next = rrts_pkg::CS_RM_RD;
          end
          rrts_pkg::FN_SLEEP:
            if (!sts.n_zero && !sts.cur_main) state_next = rrts_pkg::CS_AGE_RD;
          rrts_pkg::FN_TICK: state_next = rrts_pkg::CS_AGE_RD;
          default: ;
        endcase
      end
      rrts_pkg::CS_TRM_CLR: if (sts.idx_last) state_next = rrts_pkg::CS_DONE;
      rrts_pkg::CS_SPN_RD:  state_next = rrts_pkg::CS_SPN_CHK;
      rrts_pkg::CS_SPN_CHK:
        state_next = (sts.rd_free || sts.idx_last) ? rrts_pkg::CS_DONE
                                                   : rrts_pkg::CS_SPN_RD;
      rrts_pkg::CS_RM_RD:
        state_next = sts.rm_end ? rrts_pkg::CS_DONE : rrts_pkg::CS_RM_WR;
      rrts_pkg::CS_RM_WR:   state_next = rrts_pkg::CS_RM_RD;
      rrts_pkg::CS_AGE_RD:  state_next = rrts_pkg::CS_AGE_WR;
      rrts_pkg::CS_AGE_WR:
        if (sts.idx_last)
          state_next = (sts.func == rrts_pkg::FN_SLEEP) ? rrts_pkg::CS_SLP_RD
                                                        : rrts_pkg::CS_REQ_RD;
        else
          state_next = rrts_pkg::CS_AGE_RD;
      rrts_pkg::CS_REQ_RD:  state_next = rrts_pkg::CS_REQ_WR;
      rrts_pkg::CS_REQ_WR:  state_next = rrts_pkg::CS_DSP;
      rrts_pkg::CS_DSP:
        state_next = sts.q_empty ? rrts_pkg::CS_DONE : rrts_pkg::CS_DSP_Q;
      rrts_pkg::CS_DSP_Q:   state_next = rrts_pkg::CS_DSP_WR;
      rrts_pkg::CS_DSP_WR:  state_next = rrts_pkg::CS_DONE;
      rrts_pkg::CS_SLP_RD:  state_next = rrts_pkg::CS_SLP_WR;
      rrts_pkg::CS_SLP_WR:  state_next = rrts_pkg::CS_DSP;
      rrts_pkg::CS_DONE:    if (sts.out_free) state_next = rrts_pkg::CS_IDLE;
      default:              state_next = rrts_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = rrts_pkg::OP_NONE;
    cmd.tstat = rrts_pkg::TS_FREE;
    unique case (state)
      rrts_pkg::CS_RST_CLR, rrts_pkg::CS_TRM_CLR: cmd.op = rrts_pkg::OP_CLR;
      rrts_pkg::CS_IDLE:  if (req_valid) cmd.op = rrts_pkg::OP_LOAD;
      rrts_pkg::CS_FETCH: cmd.op = rrts_pkg::OP_RD_TGT;
      rrts_pkg::CS_DECIDE: begin
        cmd.idx_clr = 1'b1;
        case (sts.func)
          rrts_pkg::FN_SPAWN:
            if (sts.live_full) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_FULL;
            end
          rrts_pkg::FN_TERM:
            if (!sts.tgt_valid) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_BAD_ID;
            end else if (sts.tgt_main) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_END;
            end else begin
              cmd.op   = rrts_pkg::OP_FREE;
            end
          rrts_pkg::FN_BLOCK:
            if (!sts.tgt_valid) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_BAD_ID;
            end else if (sts.tgt_main) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_MAIN;
            end else if (sts.tgt_st == rrts_pkg::TS_READY ||
                         (sts.tgt_cur && sts.tgt_st == rrts_pkg::TS_RUNNING)) begin
              cmd.op    = rrts_pkg::OP_WR_TGT;
              cmd.tstat = rrts_pkg::TS_BLOCKED;
            end
          rrts_pkg::FN_RESUME:
            if (!sts.tgt_valid) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_BAD_ID;
            end else if (sts.tgt_st == rrts_pkg::TS_BLOCKED) begin
              cmd.op    = rrts_pkg::OP_WR_TGT;
              cmd.tstat = rrts_pkg::TS_READY;
              cmd.push  = 1'b1;
            end
          rrts_pkg::FN_SLEEP:
            if (sts.n_zero) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_ZERO;
            end else if (sts.cur_main) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_MAIN;
            end
          rrts_pkg::FN_QUERY:
            if (!sts.tgt_valid) begin
              cmd.op   = rrts_pkg::OP_SET_ST;
              cmd.code = rrts_pkg::RS_BAD_ID;
            end else begin
              cmd.op   = rrts_pkg::OP_QUERY;
            end
          default: ;
        endcase
      end
      rrts_pkg::CS_SPN_RD, rrts_pkg::CS_AGE_RD: cmd.op = rrts_pkg::OP_RD_IDX;
      rrts_pkg::CS_SPN_CHK:
        if (sts.rd_free) begin
          cmd.op   = rrts_pkg::OP_SPAWN;
        end else if (sts.idx_last) begin
          cmd.op   = rrts_pkg::OP_SET_ST;
          cmd.code = rrts_pkg::RS_FULL;
        end else begin
          cmd.op   = rrts_pkg::OP_IDX_INC;
        end
      rrts_pkg::CS_RM_RD:
        cmd.op = sts.rm_end ? rrts_pkg::OP_RM_END : rrts_pkg::OP_RM_RD;
      rrts_pkg::CS_RM_WR:  cmd.op = rrts_pkg::OP_RM_STEP;
      rrts_pkg::CS_AGE_WR: cmd.op = rrts_pkg::OP_AGE;
      rrts_pkg::CS_REQ_RD, rrts_pkg::CS_SLP_RD: cmd.op = rrts_pkg::OP_RD_CUR;
      rrts_pkg::CS_REQ_WR: cmd.op = rrts_pkg::OP_REQ;
      rrts_pkg::CS_DSP:    if (!sts.q_empty) cmd.op = rrts_pkg::OP_DSP_RD;
      rrts_pkg::CS_DSP_Q:  cmd.op = rrts_pkg::OP_POP;
      rrts_pkg::CS_DSP_WR: cmd.op = rrts_pkg::OP_DSP_WR;
      rrts_pkg::CS_SLP_WR: cmd.op = rrts_pkg::OP_SLP_WR;
      rrts_pkg::CS_DONE:   if (sts.out_free) cmd.op = rrts_pkg::OP_EMIT;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/round_robin_thread_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round-robin scheduler over a table of threads, a ready FIFO and sleepers.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------
//   event   | req_valid | req_stall | req (func, thread_id, quanta)
//   result  | rsp_valid | rsp_stall | rsp (status ... switched)
//
// For a switch, sleeper aging first walks every table slot; the current
// thread is then requeued if it still runs, and the head of the ready FIFO
// is dispatched. Removing a ready thread walks every queued entry, and
// spawn searches the table for a free slot. After reset, and after the
// main thread ends, a clearing pass over every table slot runs with
// req_stall high. One event is in flight at a time; a finished result
// waits in the output register while the next event is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  rrts_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output rrts_pkg::out_item_t rsp
);

  rrts_pkg::dp_cmd_t cmd;
  rrts_pkg::dp_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_datapath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  `RRTS_ASSERT_NXT(a_one_in_flight, clk, rst, req_valid && !req_stall, req_stall, "second event taken while busy")
  `RRTS_ASSERT_IMP(a_switch_ok, clk, rst, rsp_valid && rsp.switched, rsp.status == rrts_pkg::RS_OK, "switch reported with error status")
  `RRTS_ASSERT_IMP(a_end_reset, clk, rst, rsp_valid && rsp.status == rrts_pkg::RS_END, rsp.running_id == 7'd0 && rsp.total_quanta == 32'd1, "process end without reset state")

endmodule

`default_nettype wire

// ----- tb/round_robin_thread_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_tb
// Drives scheduler events through the valid/stall request channel and checks
// every response field against a behavioral scheduler model kept in the
// testbench: thread table, ready FIFO, sleep countdowns and quantum counts.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler_tb;

  localparam int NTH = 128;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  rrts_pkg::in_item_t req;
  logic rsp_valid;
  logic rsp_stall;
  rrts_pkg::out_item_t rsp;

  round_robin_thread_scheduler dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Scheduler model state.
  rrts_pkg::tstat_t m_st [NTH];
  logic        m_asleep [NTH];
  logic [15:0] m_left [NTH];
  logic [31:0] m_quanta [NTH];
  logic [6:0]  m_fifo [NTH];
  int          m_head;
  int          m_count;
  int          m_cur;
  logic [31:0] m_total;
  int          m_live;

  rrts_pkg::in_item_t  pending_events [$];
  rrts_pkg::out_item_t expected_rsp [$];

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_rsp = 0;
  int hold_count = 0;
  bit req_taken = 0;
  int errors = 0;
  int idle_cycles = 0;
  int events_sent = 0;
  int rsp_seen = 0;
  int switches_seen = 0;

  function automatic void sched_reset();
    for (int i = 0; i < NTH; i++) begin
      m_st[i] = rrts_pkg::TS_FREE;
      m_asleep[i] = 0;
      m_left[i] = '0;
      m_quanta[i] = '0;
      m_fifo[i] = '0;
    end
    m_st[0] = rrts_pkg::TS_RUNNING;
    m_quanta[0] = 1;
    m_head = 0;
    m_count = 0;
    m_cur = 0;
    m_total = 1;
    m_live = 1;
  endfunction

  function automatic void fifo_push(int id);
    if (m_count < NTH) begin
      m_fifo[(m_head + m_count) % NTH] = id[6:0];
      m_count++;
    end
  endfunction

  function automatic void fifo_drop(int id);
    int kept;
    logic [6:0] e;
    kept = 0;
    for (int i = 0; i < m_count; i++) begin
      e = m_fifo[(m_head + i) % NTH];
      if (e != id[6:0]) begin
        m_fifo[(m_head + kept) % NTH] = e;
        kept++;
      end
    end
    m_count = kept;
  endfunction

  function automatic void age_sleepers();
    for (int t = 0; t < NTH; t++) begin
      if (m_asleep[t]) begin
        if (m_left[t] > 0) m_left[t]--;
        if (m_left[t] == 0) begin
          m_asleep[t] = 0;
          if (m_st[t] == rrts_pkg::TS_READY) fifo_push(t);
        end
      end
    end
  endfunction

  function automatic bit rotate();
    int id;
    if (m_st[m_cur] == rrts_pkg::TS_RUNNING) begin
      m_st[m_cur] = rrts_pkg::TS_READY;
      fifo_push(m_cur);
    end
    if (m_count == 0) return 0;
    id = m_fifo[m_head];
    m_head = (m_head + 1) % NTH;
    m_count--;
    m_st[id] = rrts_pkg::TS_RUNNING;
    m_cur = id;
    m_quanta[id]++;
    m_total++;
    return 1;
  endfunction

  function automatic void release_slot(int id);
    m_st[id] = rrts_pkg::TS_FREE;
    m_asleep[id] = 0;
    m_left[id] = '0;
    m_quanta[id] = '0;
    if (m_live > 0) m_live--;
  endfunction

  function automatic rrts_pkg::out_item_t schedule_event(rrts_pkg::in_item_t ev);
    rrts_pkg::out_item_t r;
    int t;
    bit ok_id;
    bit sw;
    t = ev.thread_id;
    ok_id = (m_st[t] != rrts_pkg::TS_FREE);
    sw = 0;
    r = '0;
    r.status = rrts_pkg::RS_OK;
    case (ev.func)
      rrts_pkg::FN_SPAWN: begin
        r.status = rrts_pkg::RS_FULL;
        if (m_live < NTH) begin
          for (int id = 0; id < NTH; id++) begin
            if (m_st[id] == rrts_pkg::TS_FREE) begin
              m_st[id] = rrts_pkg::TS_READY;
              m_asleep[id] = 0;
              m_left[id] = '0;
              m_quanta[id] = '0;
              fifo_push(id);
              m_live++;
              r.value = id;
              r.status = rrts_pkg::RS_OK;
              break;
            end
          end
        end
      end
      rrts_pkg::FN_TERM: begin
        if (!ok_id) r.status = rrts_pkg::RS_BAD_ID;
        else if (t == 0) begin
          sched_reset();
          r.status = rrts_pkg::RS_END;
        end else if (t == m_cur && m_st[t] == rrts_pkg::TS_RUNNING) begin
          release_slot(t);
          age_sleepers();
          sw = rotate();
        end else begin
          if (m_st[t] == rrts_pkg::TS_READY) fifo_drop(t);
          release_slot(t);
        end
      end
      rrts_pkg::FN_BLOCK: begin
        if (!ok_id) r.status = rrts_pkg::RS_BAD_ID;
        else if (t == 0) r.status = rrts_pkg::RS_MAIN;
        else if (m_st[t] == rrts_pkg::TS_BLOCKED) r.status = rrts_pkg::RS_OK;
        else if (t == m_cur && m_st[t] == rrts_pkg::TS_RUNNING) begin
          m_st[t] = rrts_pkg::TS_BLOCKED;
          age_sleepers();
          sw = rotate();
        end else if (m_st[t] == rrts_pkg::TS_READY) begin
          fifo_drop(t);
          m_st[t] = rrts_pkg::TS_BLOCKED;
        end
      end
      rrts_pkg::FN_RESUME: begin
        if (!ok_id) r.status = rrts_pkg::RS_BAD_ID;
        else if (m_st[t] == rrts_pkg::TS_BLOCKED) begin
          m_st[t] = rrts_pkg::TS_READY;
          if (!m_asleep[t]) fifo_push(t);
        end
      end
      rrts_pkg::FN_SLEEP: begin
        if (ev.sleep_quanta == 0) r.status = rrts_pkg::RS_ZERO;
        else if (m_cur == 0) r.status = rrts_pkg::RS_MAIN;
        else begin
          age_sleepers();
          m_asleep[m_cur] = 1;
          m_left[m_cur] = ev.sleep_quanta;
          m_st[m_cur] = rrts_pkg::TS_READY;
          sw = rotate();
        end
      end
      rrts_pkg::FN_TICK: begin
        age_sleepers();
        sw = rotate();
      end
      rrts_pkg::FN_QUERY: begin
        if (!ok_id) r.status = rrts_pkg::RS_BAD_ID;
        else r.value = m_quanta[t];
      end
      default: ;
    endcase
    r.running_id = m_cur[6:0];
    r.total_quanta = m_total;
    r.switched = sw;
    return r;
  endfunction

  // Picks a thread id, mostly a live one so that the deep paths are reached.
  function automatic logic [6:0] pick_id();
    int id;
    if ($urandom_range(0, 9) < 2) return 7'($urandom_range(0, 127));
    for (int k = 0; k < 8; k++) begin
      id = $urandom_range(0, 127);
      if (m_live > 16) id = $urandom_range(0, 40);
      if (m_st[id] != rrts_pkg::TS_FREE) return id[6:0];
    end
    return 7'($urandom_range(1, 12));
  endfunction

  task automatic add_event(logic [2:0] f, logic [6:0] id, logic [15:0] n);
    rrts_pkg::in_item_t ev;
    ev.func = f;
    ev.thread_id = id;
    ev.sleep_quanta = n;
    pending_events = {pending_events, ev};
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: one transfer per accepted cycle, changes at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 0;
      req <= '0;
    end else if (!req_valid || req_taken) begin
      if (pending_events.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        req_valid <= 1;
        req <= pending_events.pop_front();
      end else begin
        req_valid <= 0;
      end
    end
  end

  // Receiver: a long hold-off is counted here once it is requested.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 0;
    end else if (hold_rsp) begin
      rsp_stall <= 1;
      if (hold_count >= HOLD_CYCLES - 1) begin
        hold_count <= 0;
        hold_rsp <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: the model advances at the accepted request transfer.
  always @(posedge clk) begin
    rrts_pkg::out_item_t exp_r;
    req_taken <= req_valid && !req_stall;
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req_valid && !req_stall) begin
        expected_rsp = {expected_rsp, schedule_event(req)};
        events_sent <= events_sent + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_seen <= rsp_seen + 1;
        if (rsp.switched) switches_seen <= switches_seen + 1;
        if (expected_rsp.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result %h", $time, rsp);
        end else begin
          exp_r = expected_rsp.pop_front();
          if (rsp.status !== exp_r.status || rsp.value !== exp_r.value ||
              rsp.running_id !== exp_r.running_id ||
              rsp.total_quanta !== exp_r.total_quanta ||
              rsp.switched !== exp_r.switched) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected st=%0d val=%0d run=%0d tot=%0d sw=%0d",
                     $time, exp_r.status, exp_r.value, exp_r.running_id,
                     exp_r.total_quanta, exp_r.switched);
            $display("%0t:          actual   st=%0d val=%0d run=%0d tot=%0d sw=%0d",
                     $time, rsp.status, rsp.value, rsp.running_id,
                     rsp.total_quanta, rsp.switched);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_events.size() > 0 || expected_rsp.size() > 0 || req_valid)
      @(posedge clk);
  endtask

  // Random events are planned against a shadow of the live thread count,
  // so the generator uses the model state as it stands after the drain.
  task automatic random_phase(int count);
    int f;
    for (int i = 0; i < count; i++) begin
      f = $urandom_range(0, 99);
      if (f < 18) add_event(rrts_pkg::FN_SPAWN, 7'($urandom), 16'($urandom));
      else if (f < 26) add_event(rrts_pkg::FN_TERM, (pick_id() == 0) ? 7'd1 : pick_id(),
                                 16'($urandom));
      else if (f < 38) add_event(rrts_pkg::FN_BLOCK, pick_id(), 16'($urandom));
      else if (f < 50) add_event(rrts_pkg::FN_RESUME, pick_id(), 16'($urandom));
      else if (f < 62) add_event(rrts_pkg::FN_SLEEP, 7'($urandom),
                                 ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                                 16'($urandom_range(0, 6)));
      else if (f < 88) add_event(rrts_pkg::FN_TICK, 7'($urandom), 16'($urandom));
      else if (f < 97) add_event(rrts_pkg::FN_QUERY, pick_id(), 16'($urandom));
      else if (f < 98) add_event(3'd7, 7'($urandom), 16'($urandom));
      else add_event(rrts_pkg::FN_TERM, 7'd0, 16'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    req_valid = 0;
    req = '0;
    rsp_stall = 0;
    sched_reset();
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed opening: errors on an idle main thread, then a small process.
    add_event(rrts_pkg::FN_SLEEP, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_SLEEP, 7'd0, 16'd5);
    add_event(rrts_pkg::FN_BLOCK, 7'd0, 16'hffff);
    add_event(rrts_pkg::FN_BLOCK, 7'd127, 16'd0);
    add_event(rrts_pkg::FN_QUERY, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_QUERY, 7'd127, 16'd0);
    add_event(rrts_pkg::FN_RESUME, 7'd5, 16'd0);
    add_event(rrts_pkg::FN_TERM, 7'd9, 16'd0);
    add_event(3'd7, 7'h7f, 16'hffff);
    add_event(rrts_pkg::FN_SPAWN, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_SPAWN, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_SPAWN, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_TICK, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_SLEEP, 7'd0, 16'd2);
    add_event(rrts_pkg::FN_TICK, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_BLOCK, 7'd3, 16'd0);
    add_event(rrts_pkg::FN_BLOCK, 7'd3, 16'd0);
    add_event(rrts_pkg::FN_TICK, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_RESUME, 7'd3, 16'd0);
    add_event(rrts_pkg::FN_RESUME, 7'd3, 16'd0);
    add_event(rrts_pkg::FN_TICK, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_TERM, 7'd2, 16'd0);
    add_event(rrts_pkg::FN_QUERY, 7'd1, 16'd0);
    add_event(rrts_pkg::FN_TERM, 7'd0, 16'd0);
    drain();

    // Fill the table to its limit, then one spawn too many; ids end at 127.
    for (int i = 0; i < 128; i++) add_event(rrts_pkg::FN_SPAWN, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_TICK, 7'd0, 16'd0);
    add_event(rrts_pkg::FN_SLEEP, 7'd0, 16'hffff);
    add_event(rrts_pkg::FN_QUERY, 7'd127, 16'd0);
    add_event(rrts_pkg::FN_TERM, 7'd127, 16'd0);
    add_event(rrts_pkg::FN_TERM, 7'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 65 : 0;
      stall_pct = (ph == 2) ? 65 : 0;
      if (ph == 3) begin
        idle_pct = 15;
        stall_pct = 15;
      end
      if (ph == 2) begin
        // Long receiver hold-off while events keep coming.
        hold_rsp = 1;
        random_phase(40);
        wait (!hold_rsp);
        drain();
      end
      for (int b = 0; b < 8; b++) begin
        random_phase(55);
        drain();
      end
    end

    repeat (400) @(posedge clk);
    $display("Ran %0d events, %0d results, %0d of them dispatched a thread.",
             events_sent, rsp_seen, switches_seen);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
